>>> hdl/image_abs_diff_rms_core_macros.svh
// Assertion macros for the absolute difference / RMS core checks
`ifndef IMAGE_ABS_DIFF_RMS_CORE_MACROS_SVH
`define IMAGE_ABS_DIFF_RMS_CORE_MACROS_SVH
// Consequent must hold in the same cycle as the antecedent
`define IADR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define IADR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> hdl/iadr_pkg.sv
// Shared types and constants of the absolute difference / RMS core
package iadr_pkg;

   localparam int PIX_W    = 8;
   localparam int IN_LANES = 8;
   localparam int WORD_W   = PIX_W * IN_LANES;
   localparam int SUM_W    = 32;
   localparam int FRAC_W   = 16;
   localparam int RMS_W    = 16;
   // sum of eight 8-bit differences
   localparam int ADD_W    = 11;

   typedef struct packed {
      logic [WORD_W-1:0] first_pixels;
      logic [WORD_W-1:0] second_pixels;
      logic              is_last;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   diff_word;
      logic [IN_LANES-1:0] sign_bits;
      logic [RMS_W-1:0]    rms_value;
      logic                rms_valid;
   } rsp_type;

endpackage

>>> hdl/image_abs_diff_rms_core.sv
// A request without is_last has its result registered in the cycle after acceptance;
// one with is_last goes through a bit-serial divide followed by a bit-serial square root.
// Throughput: one request per cycle while is_last is low and no response is held
// stalled; the request port stalls from an is_last acceptance until its result is
// loaded into the output register. Reset clears the state, the threshold, the running
// sum, the group count and the output valid flag.
`include "image_abs_diff_rms_core_macros.svh"

module image_abs_diff_rms_core #(
   parameter int LANES       = 8,
   parameter int COUNT_WIDTH = 21
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  iadr_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output iadr_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [iadr_pkg::PIX_W-1:0] csr_data
);
   import iadr_pkg::*;

   localparam int ACT_LANES = (LANES < IN_LANES) ? LANES : IN_LANES;
   localparam int PIX_CNT_W = COUNT_WIDTH + $clog2(LANES + 1);
   localparam int NUM_W     = SUM_W + FRAC_W;
   localparam int ROOT_W    = NUM_W / 2;

   localparam int         ST_W     = 3;
   localparam [ST_W-1:0]  ST_RUN   = 3'd0;
   localparam [ST_W-1:0]  ST_START = 3'd1;
   localparam [ST_W-1:0]  ST_DIV   = 3'd2;
   localparam [ST_W-1:0]  ST_SQRT  = 3'd3;
   localparam [ST_W-1:0]  ST_OUT   = 3'd4;

   logic [ST_W-1:0]        state_ff, state_in;
   logic [PIX_W-1:0]       thr_ff, thr_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_data_ff, out_data_in;
   logic [WORD_W-1:0]      hold_diff_ff, hold_diff_in;
   logic [IN_LANES-1:0]    hold_sign_ff, hold_sign_in;

   logic [ACT_LANES-1:0][PIX_W-1:0] abs_diff;
   logic [ACT_LANES-1:0][PIX_W-1:0] mask_diff;
   logic [ACT_LANES-1:0]            lane_sign;
   logic [WORD_W-1:0]               diff_word_c;
   logic [IN_LANES-1:0]             sign_bits_c;
   logic [ADD_W-1:0]                lane_sum_c;

   logic [SUM_W:0]         sum_ext;
   logic [SUM_W-1:0]       sum_acc;
   logic [COUNT_WIDTH-1:0] count_acc;
   logic [PIX_CNT_W-1:0]   pixel_count;
   logic                   req_accept;
   logic                   out_ready;
   logic                   div_start;
   logic                   div_done;
   logic [NUM_W-1:0]       quotient;
   logic                   sqrt_done;
   logic [ROOT_W-1:0]      root;

   for (genvar k = 0; k < ACT_LANES; k++) begin : g_lane
      iadr_lane u_lane (
         .first_pix  (req_data.first_pixels[k*PIX_W +: PIX_W]),
         .second_pix (req_data.second_pixels[k*PIX_W +: PIX_W]),
         .threshold  (thr_ff),
         .abs_diff   (abs_diff[k]),
         .mask_diff  (mask_diff[k]),
         .sign       (lane_sign[k])
      );
   end

   iadr_merge #(
      .ACT_LANES (ACT_LANES)
   ) u_merge (
      .abs_diff  (abs_diff),
      .mask_diff (mask_diff),
      .lane_sign (lane_sign),
      .diff_word (diff_word_c),
      .sign_bits (sign_bits_c),
      .lane_sum  (lane_sum_c)
   );

   iadr_div #(
      .NUM_W (NUM_W),
      .DEN_W (PIX_CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, FRAC_W'(0)}),
      .divisor  (pixel_count),
      .done     (div_done),
      .quotient (quotient)
   );

   iadr_sqrt #(
      .RAD_W (NUM_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (div_done),
      .radicand (quotient),
      .done     (sqrt_done),
      .root     (root)
   );

   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_RUN) || (out_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign div_start  = (state_ff == ST_START);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   always_comb begin
      // saturating accumulate of this request's raw differences
      sum_ext     = {1'b0, sum_ff} + (SUM_W + 1)'(lane_sum_c);
      sum_acc     = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      count_acc   = (count_ff == '1) ? count_ff : count_ff + COUNT_WIDTH'(1);
      pixel_count = PIX_CNT_W'(count_ff) * PIX_CNT_W'(LANES);

      state_in     = state_ff;
      thr_in       = thr_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      hold_diff_in = hold_diff_ff;
      hold_sign_in = hold_sign_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         thr_in = csr_data;
      end

      unique case (state_ff)
         ST_RUN: begin
            if (req_accept) begin
               sum_in   = sum_acc;
               count_in = count_acc;
               if (req_data.is_last) begin
                  hold_diff_in = diff_word_c;
                  hold_sign_in = sign_bits_c;
                  state_in     = ST_START;
               end else begin
                  out_valid_in = 1'b1;
                  out_data_in  = '{diff_word: diff_word_c, sign_bits: sign_bits_c,
                                   rms_value: '0, rms_valid: 1'b0};
               end
            end
         end
         ST_START: begin
            // divider latches the frame totals at this edge; clear them for the next frame
            sum_in   = '0;
            count_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               out_valid_in = 1'b1;
               out_data_in  = '{diff_word: hold_diff_ff, sign_bits: hold_sign_ff,
                                rms_value: root[RMS_W-1:0], rms_valid: 1'b1};
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         thr_ff       <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff  <= out_data_in;
      hold_diff_ff <= hold_diff_in;
      hold_sign_ff <= hold_sign_in;
   end

   `IADR_ASSERT_NEXT(a_last_starts_root, clock, reset, req_accept && req_data.is_last, state_ff == ST_START && count_ff != '0, "last request did not start rms with a nonzero count")
   `IADR_ASSERT_NEXT(a_frame_cleared, clock, reset, state_ff == ST_START, sum_ff == '0 && count_ff == '0, "frame totals not cleared after rms start")
   `IADR_ASSERT_SAME(a_div_done_state, clock, reset, div_done, state_ff == ST_DIV, "divider finished outside the divide phase")
   `IADR_ASSERT_SAME(a_sqrt_done_state, clock, reset, sqrt_done, state_ff == ST_SQRT, "square root finished outside the root phase")

endmodule

>>> hdl/iadr_lane.sv
// One pixel lane: absolute difference, threshold mask and sign
module iadr_lane (
   input  logic [iadr_pkg::PIX_W-1:0] first_pix,
   input  logic [iadr_pkg::PIX_W-1:0] second_pix,
   input  logic [iadr_pkg::PIX_W-1:0] threshold,
   output logic [iadr_pkg::PIX_W-1:0] abs_diff,
   output logic [iadr_pkg::PIX_W-1:0] mask_diff,
   output logic                       sign
);
   import iadr_pkg::*;

   always_comb begin
      sign      = (second_pix < first_pix);
      abs_diff  = sign ? (first_pix - second_pix) : (second_pix - first_pix);
      mask_diff = (abs_diff > threshold) ? abs_diff : '0;
   end

endmodule

>>> hdl/iadr_merge.sv
// Merge of lane results: pack the words and sum the raw differences
module iadr_merge #(
   parameter int ACT_LANES = 8
) (
   input  logic [ACT_LANES-1:0][iadr_pkg::PIX_W-1:0] abs_diff,
   input  logic [ACT_LANES-1:0][iadr_pkg::PIX_W-1:0] mask_diff,
   input  logic [ACT_LANES-1:0]                      lane_sign,
   output logic [iadr_pkg::WORD_W-1:0]               diff_word,
   output logic [iadr_pkg::IN_LANES-1:0]             sign_bits,
   output logic [iadr_pkg::ADD_W-1:0]                lane_sum
);
   import iadr_pkg::*;

   for (genvar k = 0; k < IN_LANES; k++) begin : g_pack
      if (k < ACT_LANES) begin : g_used
         assign diff_word[k*PIX_W +: PIX_W] = mask_diff[k];
         assign sign_bits[k]                = lane_sign[k];
      end else begin : g_unused
         assign diff_word[k*PIX_W +: PIX_W] = '0;
         assign sign_bits[k]                = 1'b0;
      end
   end

   always_comb begin
      lane_sum = '0;
      for (int k = 0; k < ACT_LANES; k++) begin
         lane_sum = lane_sum + ADD_W'(abs_diff[k]);
      end
   end

endmodule

>>> hdl/iadr_div.sv
// Restoring divider, one quotient bit per cycle
module iadr_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      rem_sub   = rem_shift - {1'b0, den_ff};
      fits      = (rem_shift >= {1'b0, den_ff});

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/iadr_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle
module iadr_sqrt #(
   parameter int RAD_W = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RAD_W-1:0]   radicand,
   output logic               done,
   output logic [RAD_W/2-1:0] root
);
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int CNT_W  = $clog2(ROOT_W);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;
   logic              fits;

   always_comb begin
      // bring down the next two radicand bits
      rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      fits      = (rem_shift >= trial);

      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = fits ? (rem_shift - trial) : rem_shift;
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
